[rtl/core/polyline_offset_points_macros.svh]
// Assertion macros shared by the polyline offset RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef POLYLINE_OFFSET_POINTS_MACROS_SVH
`define POLYLINE_OFFSET_POINTS_MACROS_SVH

// Check on every clock edge once reset is released
`define POP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that post holds in the cycle after pre, reset released on both edges
`define POP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/core/pop_pkg.sv]
// Package for the polyline offset block: field widths, FSM state type and
// the control structs passed between the sequencer, root lanes and output stage.
package pop_pkg;

    localparam int COORD_W       = 16;   // vertex coordinate
    localparam int DIFF_W        = 17;   // chord component and its magnitude
    localparam int WIDTH_W       = 13;   // stroke width register
    localparam int OUT_W         = 21;   // offset point coordinate
    localparam int SQ_W          = 34;   // ex^2 + ey^2
    localparam int N_W           = 29;   // stroke width times chord magnitude
    localparam int NSQ_W         = 2 * N_W;
    localparam int FRAC_BITS_DEF = 4;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(16);

    localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
    localparam int OUT_MIN = -(2 ** (OUT_W - 1));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_INIT,
        ST_ROOT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_root_ctl;

    typedef struct packed {
        logic degen;    // both neighbors coincide
        logic oy_neg;   // y offset of the right point is negative
        logic oy_zero;  // vertical chord, y offset is zero
    } t_sign;

endpackage

[rtl/core/polyline_offset_points.sv]
// Top level of the polyline offset block: vertex history, sequencer, multiply
// stages and two root lanes. Depends on pop_pkg, pop_root and pop_pack.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready      | i_x, i_y, i_first
//  out     | output    | o_out_valid / i_out_ready    | o_left_x/y, o_right_x/y, o_degenerate
//  cfg     | input     | i_cfg_wr_en (no wait)        | i_cfg_wr_data (stroke width)
//
// A vertex that yields offset points passes two multiply stages, a load, one root bit per
// cycle in the root lanes and a hand-off state before the next vertex is accepted. A vertex
// with no result is accepted while the sequencer stays idle.
// A finished beat waits in the output register while new vertices are taken; the next
// result holds in its last state until that register drains.
// Synchronous active-low reset clears the history, the sequencer and the width to 16.
`include "polyline_offset_points_macros.svh"

module polyline_offset_points import pop_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [WIDTH_W-1:0]         i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [COORD_W-1:0]  i_x,
    input  logic signed [COORD_W-1:0]  i_y,
    input  logic                       i_first,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [OUT_W-1:0]    o_left_x,
    output logic signed [OUT_W-1:0]    o_left_y,
    output logic signed [OUT_W-1:0]    o_right_x,
    output logic signed [OUT_W-1:0]    o_right_y,
    output logic                       o_degenerate
);

    localparam int TW    = WIDTH_W + FRAC_BITS;
    localparam int BIT_W = $clog2(TW);

    t_state r_state;
    t_state n_state;

    logic [WIDTH_W-1:0]        r_width;
    logic [1:0]                r_held;
    logic signed [COORD_W-1:0] r_old_x;
    logic signed [COORD_W-1:0] r_old_y;
    logic signed [COORD_W-1:0] r_new_x;
    logic signed [COORD_W-1:0] r_new_y;
    logic [BIT_W-1:0]          r_bit;

    logic signed [COORD_W-1:0] r_mid_x;
    logic signed [COORD_W-1:0] r_mid_y;
    logic [DIFF_W-1:0]         r_ax;
    logic [DIFF_W-1:0]         r_ay;
    t_sign                     r_sgn;
    logic [SQ_W-1:0]           r_ax2;
    logic [SQ_W-1:0]           r_ay2;
    logic [N_W-1:0]            r_nx;
    logic [N_W-1:0]            r_ny;
    logic [SQ_W-1:0]           r_sq;
    logic [NSQ_W-1:0]          r_nsq_x;
    logic [NSQ_W-1:0]          r_nsq_y;

    logic                      w_accept;
    logic                      w_produce;
    logic                      w_free;
    logic                      w_load;
    t_root_ctl                 w_ctl;
    logic signed [DIFF_W-1:0]  w_ex;
    logic signed [DIFF_W-1:0]  w_ey;
    logic [DIFF_W-1:0]         w_ax;
    logic [DIFF_W-1:0]         w_ay;
    t_sign                     w_sgn;
    logic [N_W:0]              w_nx;
    logic [N_W:0]              w_ny;
    logic [TW-1:0]             w_qx;
    logic [TW-1:0]             w_qy;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_produce = !i_first && (r_held == 2'd2);
    assign w_free    = !o_out_valid || i_out_ready;

    // Chord across the middle vertex, its magnitudes, offset signs and width products
    always_comb begin
        w_ex          = DIFF_W'(i_x) - DIFF_W'(r_old_x);
        w_ey          = DIFF_W'(i_y) - DIFF_W'(r_old_y);
        w_ax          = w_ex[DIFF_W-1] ? DIFF_W'(-w_ex) : DIFF_W'(w_ex);
        w_ay          = w_ey[DIFF_W-1] ? DIFF_W'(-w_ey) : DIFF_W'(w_ey);
        w_sgn.degen   = (w_ex == '0) && (w_ey == '0);
        w_sgn.oy_zero = (w_ex == '0);
        w_sgn.oy_neg  = (!w_ey[DIFF_W-1]) == (!w_ex[DIFF_W-1] && (w_ex != '0));
        w_nx          = (N_W + 1)'(r_width) * (N_W + 1)'(r_ay);
        w_ny          = (N_W + 1)'(r_width) * (N_W + 1)'(r_ax);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept && w_produce) n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_INIT;
            ST_INIT: n_state = ST_ROOT;
            ST_ROOT: if (r_bit == '0) n_state = ST_DONE;
            ST_DONE: if (w_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_ctl      = '0;
        w_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_INIT: w_ctl.load = 1'b1;
            ST_ROOT: w_ctl.step = 1'b1;
            ST_DONE: w_load     = w_free;
            default: ;
        endcase
    end

    // Control state, width register and vertex history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_width <= WIDTH_RESET;
            r_held  <= 2'd0;
            r_old_x <= '0;
            r_old_y <= '0;
            r_new_x <= '0;
            r_new_y <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_width <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_old_x <= r_new_x;
                r_old_y <= r_new_y;
                r_new_x <= i_x;
                r_new_y <= i_y;
                if (i_first) begin
                    r_held <= 2'd1;
                end else if (r_held != 2'd2) begin
                    r_held <= r_held + 2'd1;
                end
            end
            if (r_state == ST_INIT) begin
                r_bit <= BIT_W'(TW - 1);
            end else if (r_state == ST_ROOT) begin
                r_bit <= r_bit - BIT_W'(1);
            end
        end
    end

    // Capture the chord, then square and scale over two stages
    always_ff @(posedge i_clk) begin
        if (w_accept && w_produce) begin
            r_mid_x <= r_new_x;
            r_mid_y <= r_new_y;
            r_ax    <= w_ax;
            r_ay    <= w_ay;
            r_sgn   <= w_sgn;
        end
        if (r_state == ST_MUL1) begin
            r_ax2 <= SQ_W'(r_ax) * SQ_W'(r_ax);
            r_ay2 <= SQ_W'(r_ay) * SQ_W'(r_ay);
            r_nx  <= w_nx[N_W-1:0];
            r_ny  <= w_ny[N_W-1:0];
        end
        if (r_state == ST_MUL2) begin
            r_sq    <= r_ax2 + r_ay2;
            r_nsq_x <= NSQ_W'(r_nx) * NSQ_W'(r_nx);
            r_nsq_y <= NSQ_W'(r_ny) * NSQ_W'(r_ny);
        end
    end

    // Root lane for the x offset (from |ey|) and for the y offset (from |ex|)
    pop_root #(.FRAC_BITS(FRAC_BITS)) u_root_x (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_nsq (r_nsq_x),
        .i_sq  (r_sq),
        .o_q   (w_qx)
    );

    pop_root #(.FRAC_BITS(FRAC_BITS)) u_root_y (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_nsq (r_nsq_y),
        .i_sq  (r_sq),
        .o_q   (w_qy)
    );

    pop_pack #(.FRAC_BITS(FRAC_BITS)) u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_mid_x      (r_mid_x),
        .i_mid_y      (r_mid_y),
        .i_qx         (w_qx),
        .i_qy         (w_qy),
        .i_sgn        (r_sgn),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_left_x     (o_left_x),
        .o_left_y     (o_left_y),
        .o_right_x    (o_right_x),
        .o_right_y    (o_right_y),
        .o_degenerate (o_degenerate)
    );

    `POP_ASSERT(a_held_range, (r_held != 2'd3), "held vertex count out of range")
    `POP_ASSERT(a_valid_from_done, $rose(o_out_valid) |-> $past(r_state == ST_DONE), "result beat raised outside the final state")
    `POP_ASSERT_NEXT(a_root_start, (r_state == ST_INIT), (r_state == ST_ROOT && r_bit == BIT_W'(TW - 1)), "root iteration did not start at the top bit")
    `POP_ASSERT_NEXT(a_produce_starts, (w_accept && w_produce), (r_state == ST_MUL1), "third vertex did not start the offset computation")

endmodule

[rtl/core/pop_root.sv]
// One root lane: finds t = floor(num / sqrt(sq)) one bit per cycle while step is set, MSB first,
// and returns the rounded half q = (t + 1) / 2. Depends on pop_pkg.
module pop_root import pop_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  t_root_ctl                     i_ctl,
    input  logic [NSQ_W-1:0]              i_nsq,
    input  logic [SQ_W-1:0]               i_sq,
    output logic [WIDTH_W+FRAC_BITS-1:0]  o_q
);

    localparam int TW = WIDTH_W + FRAC_BITS;
    localparam int RW = 2 * TW + SQ_W;

    // r_rem = num^2 - t^2*sq, r_a = t*sq*2^(b+1), r_b = sq*2^(2b)
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_a;
    logic [RW-1:0] r_b;
    logic [TW-1:0] r_t;

    logic [RW-1:0] w_trial;
    logic [RW:0]   w_diff;
    logic          w_take;
    logic [RW-1:0] w_a_acc;
    logic [TW:0]   w_t1;

    // Trial subtract for the current bit
    always_comb begin
        w_trial = r_a + r_b;
        w_diff  = {1'b0, r_rem} - {1'b0, w_trial};
        w_take  = ~w_diff[RW];
        w_a_acc = w_take ? (w_trial + r_b) : r_a;
    end

    // Load operands, then advance one root bit per step
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= RW'(i_nsq) << (2 * FRAC_BITS);
            r_a   <= '0;
            r_b   <= RW'(i_sq) << (2 * TW - 2);
            r_t   <= '0;
        end else if (i_ctl.step) begin
            if (w_take) begin
                r_rem <= w_diff[RW-1:0];
            end
            r_a <= w_a_acc >> 1;
            r_b <= r_b >> 2;
            r_t <= {r_t[TW-2:0], w_take};
        end
    end

    // Round to nearest, ties away from zero
    assign w_t1 = {1'b0, r_t} + (TW + 1)'(1);
    assign o_q  = w_t1[TW:1];

endmodule

[rtl/core/pop_pack.sv]
// Output stage: applies offset signs, adds them to the middle vertex, saturates
// and holds the result beat in the output register. Depends on pop_pkg.
`include "polyline_offset_points_macros.svh"

module pop_pack import pop_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic signed [COORD_W-1:0]     i_mid_x,
    input  logic signed [COORD_W-1:0]     i_mid_y,
    input  logic [WIDTH_W+FRAC_BITS-1:0]  i_qx,
    input  logic [WIDTH_W+FRAC_BITS-1:0]  i_qy,
    input  t_sign                         i_sgn,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [OUT_W-1:0]       o_left_x,
    output logic signed [OUT_W-1:0]       o_left_y,
    output logic signed [OUT_W-1:0]       o_right_x,
    output logic signed [OUT_W-1:0]       o_right_y,
    output logic                          o_degenerate
);

    localparam int TW = WIDTH_W + FRAC_BITS;
    localparam int SW = COORD_W + FRAC_BITS + 2;
    localparam int EW = (SW > OUT_W) ? SW : OUT_W + 1;
    localparam logic signed [EW-1:0] E_MAX = EW'(OUT_MAX);
    localparam logic signed [EW-1:0] E_MIN = EW'(OUT_MIN);

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > E_MAX) begin
            e = E_MAX;
        end else if (e < E_MIN) begin
            e = E_MIN;
        end
        return e[OUT_W-1:0];
    endfunction

    logic                    r_valid;
    logic signed [OUT_W-1:0] r_left_x;
    logic signed [OUT_W-1:0] r_left_y;
    logic signed [OUT_W-1:0] r_right_x;
    logic signed [OUT_W-1:0] r_right_y;
    logic                    r_degen;

    logic signed [SW-1:0] w_mx;
    logic signed [SW-1:0] w_my;
    logic signed [SW-1:0] w_ox;
    logic signed [SW-1:0] w_oy_mag;
    logic signed [SW-1:0] w_oy;

    // Scale the middle vertex and build signed offsets
    always_comb begin
        w_mx     = SW'(i_mid_x) <<< FRAC_BITS;
        w_my     = SW'(i_mid_y) <<< FRAC_BITS;
        w_ox     = i_sgn.degen ? '0 : SW'($signed({1'b0, i_qx}));
        w_oy_mag = (i_sgn.degen || i_sgn.oy_zero) ? '0 : SW'($signed({1'b0, i_qy}));
        w_oy     = i_sgn.oy_neg ? -w_oy_mag : w_oy_mag;
    end

    // Hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left_x  <= sat(w_mx - w_ox);
            r_left_y  <= sat(w_my - w_oy);
            r_right_x <= sat(w_mx + w_ox);
            r_right_y <= sat(w_my + w_oy);
            r_degen   <= i_sgn.degen;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_left_x     = r_left_x;
    assign o_left_y     = r_left_y;
    assign o_right_x    = r_right_x;
    assign o_right_y    = r_right_y;
    assign o_degenerate = r_degen;

    `POP_ASSERT(a_degen_points_meet, (r_valid && r_degen) |-> (r_left_x == r_right_x && r_left_y == r_right_y), "degenerate beat with distinct points")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench for polyline_offset_points: streams polyline vertices, predicts each offset-point
// beat with an exact integer model or a directed row, and checks every beat field by field.
// Depends on pop_pkg and the polyline_offset_points RTL only.
module tb;
    import pop_pkg::*;

    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int N_ROWS   = 24;
    localparam int N_PHASES = 6;
    localparam int PHASE_N  = 75;
    localparam int SETTLE   = 40;    // worth of one root pass plus margin

    typedef struct packed {
        logic signed [OUT_W-1:0] left_x;
        logic signed [OUT_W-1:0] left_y;
        logic signed [OUT_W-1:0] right_x;
        logic signed [OUT_W-1:0] right_y;
        logic                    degenerate;
    } t_offset_pts;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      first;
        logic                      typed;
        t_offset_pts               pts;
    } t_vertex_row;

    // Directed vertices; pts is only meaningful where typed is set
    localparam t_vertex_row DIRECTED [N_ROWS] = '{
        '{0, 0, 0, 0, '{0, 0, 0, 0, 0}},            // held after reset without a start
        '{5, 5, 0, 0, '{0, 0, 0, 0, 0}},
        '{10, 0, 0, 1, '{80, 208, 80, -48, 0}},     // horizontal chord
        '{100, 100, 1, 0, '{0, 0, 0, 0, 0}},        // restart
        '{0, 0, 0, 0, '{0, 0, 0, 0, 0}},
        '{100, 100, 0, 1, '{0, 0, 0, 0, 1}},        // neighbors coincide
        '{0, 40, 0, 1, '{1472, 1600, 1728, 1600, 0}}, // vertical chord
        '{-32768, -32768, 1, 0, '{0, 0, 0, 0, 0}},
        '{32767, 32767, 0, 0, '{0, 0, 0, 0, 0}},
        '{32767, -32768, 0, 1, '{524272, 524400, 524272, 524144, 0}},
        '{-32768, 32767, 0, 1, '{524272, -524416, 524272, -524160, 0}},
        '{-32768, -32768, 0, 0, '{0, 0, 0, 0, 0}},
        '{32767, 32767, 0, 0, '{0, 0, 0, 0, 0}},
        '{-32768, -32768, 1, 0, '{0, 0, 0, 0, 0}},
        '{0, 0, 0, 0, '{0, 0, 0, 0, 0}},
        '{32767, 32767, 0, 0, '{0, 0, 0, 0, 0}},    // longest diagonal chord
        '{1, 1, 1, 0, '{0, 0, 0, 0, 0}},
        '{0, 0, 1, 0, '{0, 0, 0, 0, 0}},            // back-to-back restarts
        '{9, -2, 0, 0, '{0, 0, 0, 0, 0}},
        '{3, 4, 0, 0, '{0, 0, 0, 0, 0}},
        '{-3, -4, 0, 0, '{0, 0, 0, 0, 0}},          // chord pointing down and left
        '{10, 0, 0, 0, '{0, 0, 0, 0, 0}},           // chord pointing down and right
        '{-3, -4, 0, 1, '{160, 0, 160, 0, 1}},
        '{-3, 50, 0, 0, '{0, 0, 0, 0, 0}}
    };

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_wr_en   = 1'b0;
    logic [WIDTH_W-1:0]        i_cfg_wr_data = '0;
    logic                      i_in_valid    = 1'b0;
    logic signed [COORD_W-1:0] i_x           = '0;
    logic signed [COORD_W-1:0] i_y           = '0;
    logic                      i_first       = 1'b0;
    logic                      i_out_ready   = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic signed [OUT_W-1:0]   o_left_x;
    logic signed [OUT_W-1:0]   o_left_y;
    logic signed [OUT_W-1:0]   o_right_x;
    logic signed [OUT_W-1:0]   o_right_y;
    logic                      o_degenerate;

    // Predictor state: stroke width and vertex history
    logic [WIDTH_W-1:0] width_setting = WIDTH_RESET;
    longint             hist_old_x = 0;
    longint             hist_old_y = 0;
    longint             hist_new_x = 0;
    longint             hist_new_y = 0;
    int                 hist_count = 0;

    // Stimulus-side vertex history, used to steer chords
    logic signed [COORD_W-1:0] gen_x1 = '0;
    logic signed [COORD_W-1:0] gen_y1 = '0;
    logic signed [COORD_W-1:0] gen_x2 = '0;
    logic signed [COORD_W-1:0] gen_y2 = '0;

    t_offset_pts pending_offsets [$];
    int          mismatch_count = 0;
    int          in_idle_pct    = 0;
    int          out_idle_pct   = 0;

    polyline_offset_points dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_first       (i_first),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left_x      (o_left_x),
        .o_left_y      (o_left_y),
        .o_right_x     (o_right_x),
        .o_right_y     (o_right_y),
        .o_degenerate  (o_degenerate)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Largest q with (2q-1)^2 * sq <= (W*comp*2^FRAC)^2: the rounded half-width offset
    function automatic longint unsigned offset_mag(input longint unsigned comp,
                                                   input longint unsigned sq);
        logic [127:0]     target;
        logic [127:0]     trial;
        longint unsigned  num;
        longint unsigned  lo;
        longint unsigned  hi;
        longint unsigned  mid;
        longint unsigned  d;
        num    = (64'(width_setting) * comp) << FRAC;
        target = 128'(num) * 128'(num);
        lo     = 0;
        hi     = 64'd2097151;
        while (lo < hi) begin
            mid   = (lo + hi + 1) / 2;
            d     = 2 * mid - 1;
            trial = 128'(d) * 128'(d) * 128'(sq);
            if (trial <= target) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    function automatic logic signed [OUT_W-1:0] saturate(input longint v);
        if (v > OUT_MAX) begin
            return OUT_W'(OUT_MAX);
        end else if (v < OUT_MIN) begin
            return OUT_W'(OUT_MIN);
        end
        return OUT_W'(v);
    endfunction

    // Advance the vertex history; return 1 with the offset points when a beat is due
    function automatic bit next_vertex(input logic signed [COORD_W-1:0] vx,
                                       input logic signed [COORD_W-1:0] vy,
                                       input logic vfirst, output t_offset_pts pts);
        longint          ex;
        longint          ey;
        longint          mx;
        longint          my;
        longint          ox;
        longint          oy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned sq;
        bit              emit;
        emit = 1'b0;
        pts  = '0;
        if (vfirst) begin
            hist_count = 0;
        end else if (hist_count >= 2) begin
            ex = longint'(vx) - hist_old_x;
            ey = longint'(vy) - hist_old_y;
            ax = (ex < 0) ? -ex : ex;
            ay = (ey < 0) ? -ey : ey;
            sq = ax * ax + ay * ay;
            mx = hist_new_x * (longint'(1) << FRAC);
            my = hist_new_y * (longint'(1) << FRAC);
            ox = 0;
            oy = 0;
            if (sq == 0) begin
                pts.degenerate = 1'b1;
            end else begin
                ox = longint'(offset_mag(ay, sq));
                if (ex != 0) begin
                    oy = longint'(offset_mag(ax, sq));
                    // right point turns clockwise from the chord, folded to ey >= 0
                    if ((ey >= 0) == (ex > 0)) begin
                        oy = -oy;
                    end
                end
            end
            pts.left_x  = saturate(mx - ox);
            pts.left_y  = saturate(my - oy);
            pts.right_x = saturate(mx + ox);
            pts.right_y = saturate(my + oy);
            emit = 1'b1;
        end
        hist_old_x = hist_new_x;
        hist_old_y = hist_new_y;
        hist_new_x = longint'(vx);
        hist_new_y = longint'(vy);
        if (hist_count < 2) begin
            hist_count++;
        end
        return emit;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Offer one vertex beat, hold it until accepted, then record what it should produce
    task automatic push_vertex(input logic signed [COORD_W-1:0] vx,
                               input logic signed [COORD_W-1:0] vy, input logic vfirst,
                               input bit typed, input t_offset_pts typed_pts);
        t_offset_pts pts;
        bit          emit;
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_x        <= vx;
        i_y        <= vy;
        i_first    <= vfirst;
        do @(posedge i_clk); while (!o_in_ready);
        emit = next_vertex(vx, vy, vfirst, pts);
        if (typed) begin
            pending_offsets.insert(pending_offsets.size(), typed_pts);
        end else if (emit) begin
            pending_offsets.insert(pending_offsets.size(), pts);
        end
    endtask

    // Drain, let the root lanes settle, then write the stroke width
    task automatic set_stroke_width(input logic [WIDTH_W-1:0] w);
        i_in_valid <= 1'b0;
        while (pending_offsets.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        width_setting = w;
    endtask

    function automatic logic signed [COORD_W-1:0] corner_value();
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    // Mostly walk near the last vertex; mix in axis-aligned and coinciding chords,
    // wide jumps, corners and restarts
    task automatic random_vertex(output logic signed [COORD_W-1:0] vx,
                                 output logic signed [COORD_W-1:0] vy, output logic vfirst);
        int pick;
        int span;
        pick   = $urandom_range(0, 99);
        vfirst = ($urandom_range(0, 99) < 7);
        span   = ($urandom_range(0, 2) == 0) ? 7 : (($urandom_range(0, 1) == 0) ? 255 : 4095);
        vx     = 16'(int'(gen_x1) + int'($urandom_range(0, 2 * span)) - span);
        vy     = 16'(int'(gen_y1) + int'($urandom_range(0, 2 * span)) - span);
        if (pick >= 50 && pick < 65) begin
            case ($urandom_range(0, 2))
                0: begin
                    vx = gen_x2;
                    vy = gen_y2;
                end
                1:       vx = gen_x2;
                default: vy = gen_y2;
            endcase
        end else if (pick >= 65 && pick < 90) begin
            vx = 16'($urandom);
            vy = 16'($urandom);
        end else if (pick >= 90) begin
            vx = corner_value();
            vy = corner_value();
        end
        gen_x2 = gen_x1;
        gen_y2 = gen_y1;
        gen_x1 = vx;
        gen_y1 = vy;
    endtask

    // Take result beats, compare with the oldest prediction, randomize ready
    always @(posedge i_clk) begin
        t_offset_pts got;
        t_offset_pts want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_left_x, o_left_y, o_right_x, o_right_y, o_degenerate};
            if (pending_offsets.size() == 0) begin
                log_mismatch($sformatf("unexpected beat: L(%0d,%0d) R(%0d,%0d) deg %0b",
                    got.left_x, got.left_y, got.right_x, got.right_y, got.degenerate));
            end else begin
                want = pending_offsets.pop_front();
                if (got.left_x !== want.left_x || got.left_y !== want.left_y ||
                    got.right_x !== want.right_x || got.right_y !== want.right_y ||
                    got.degenerate !== want.degenerate) begin
                    log_mismatch($sformatf(
                        "mismatch: exp L(%0d,%0d) R(%0d,%0d) d %0b got L(%0d,%0d) R(%0d,%0d) d %0b",
                        want.left_x, want.left_y, want.right_x, want.right_y, want.degenerate,
                        got.left_x, got.left_y, got.right_x, got.right_y, got.degenerate));
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    initial begin
        logic [WIDTH_W-1:0]        phase_width [N_PHASES];
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic                      vfirst;
        phase_width = '{13'd8191, 13'd0, 13'd1, 13'($urandom), 13'd16, 13'($urandom)};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed vertices at the reset width, no idling
        for (int r = 0; r < N_ROWS; r++) begin
            push_vertex(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].first,
                        DIRECTED[r].typed, DIRECTED[r].pts);
        end

        // Random phases: receiver-heavy idling, then sender-heavy, then none
        for (int p = 0; p < N_PHASES; p++) begin
            case (p / 2)
                0: begin
                    in_idle_pct  = 38;
                    out_idle_pct = 85;
                end
                1: begin
                    in_idle_pct  = 85;
                    out_idle_pct = 38;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            set_stroke_width(phase_width[p]);
            for (int n = 0; n < PHASE_N; n++) begin
                random_vertex(vx, vy, vfirst);
                push_vertex(vx, vy, vfirst, 1'b0, '0);
            end
        end

        // Drain and watch for stray beats
        i_in_valid <= 1'b0;
        while (pending_offsets.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[polyline_offset_points] OK");
        end else begin
            $display("[polyline_offset_points] ERROR");
        end
        $finish;
    end

    // Hold the run to a fixed budget
    initial begin
        #2_000_000;
        $display("[polyline_offset_points] ERROR");
        $finish;
    end

endmodule
